// ===== hdl/k_mismatch_window_matcher_assert.svh =====
// Assertion macros for the k-mismatch window matcher.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef K_MISMATCH_WINDOW_MATCHER_ASSERT_SVH
`define K_MISMATCH_WINDOW_MATCHER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define KMWM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kmwm assertion failed");

// Next-cycle implication.
`define KMWM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kmwm assertion failed");

`else

`define KMWM_ASSERT_IMP(label, ante, cons)
`define KMWM_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== hdl/kmwm_pkg.sv =====
package kmwm_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int RES_W       = 8;
  localparam int POS_W       = 16;
  localparam int CNT_W       = 5;
  localparam int HALF_W      = 64;
  localparam int WIN_W       = PATTERN_MAX * RES_W;
  localparam int CFG_W       = 64;

  localparam logic [POS_W-1:0] LINE_MAX = 16'hFFFF;
  localparam logic [CNT_W-1:0] TOL      = 5'd2;

  typedef enum logic [1:0] {
    CFG_PATTERN_LOW    = 2'd0,
    CFG_PATTERN_HIGH   = 2'd1,
    CFG_PATTERN_LENGTH = 2'd2,
    CFG_TOLERANCE      = 2'd3
  } cfg_index_t;

  // Pattern length in use: zero counts as one, anything above the maximum is clipped.
  function automatic logic [CNT_W-1:0] active_len(input logic [CNT_W-1:0] len);
    logic [CNT_W-1:0] n;
    n = len;
    if (n == '0) begin
      n = CNT_W'(1);
    end else if (n > CNT_W'(PATTERN_MAX)) begin
      n = CNT_W'(PATTERN_MAX);
    end
    return n;
  endfunction

endpackage

// ===== hdl/k_mismatch_window_matcher.sv =====
// An accepted item is registered in stage one, and its result then in the result register that drives out_*.
// Throughput: one item per cycle; the compare stage advances every cycle unless the result register is held
// by out_ready low, and the history register takes a new item unless stage one is also full.
// Reset (rst_n low, synchronous): pattern cleared, length 1, tolerance 2, line count zero,
// both pipeline stages empty.
`include "k_mismatch_window_matcher_assert.svh"

module k_mismatch_window_matcher (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [kmwm_pkg::CFG_W-1:0]      cfg_data,

  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [kmwm_pkg::RES_W-1:0]      in_residue,
  input  logic                            in_line_start,

  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [kmwm_pkg::POS_W-1:0]      out_start_position,
  output logic [kmwm_pkg::CNT_W-1:0]      out_mismatch_count,
  output logic [kmwm_pkg::HALF_W-1:0]     out_window_low,
  output logic [kmwm_pkg::HALF_W-1:0]     out_window_high
);

  // Configuration registers.
  logic [kmwm_pkg::HALF_W-1:0] pat_lo_r;
  logic [kmwm_pkg::HALF_W-1:0] pat_hi_r;
  logic [kmwm_pkg::CNT_W-1:0]  pat_len_r;
  logic [kmwm_pkg::CNT_W-1:0]  tol_r;

  // Stage one: residue history and line count, updated when an item is accepted.
  // The newest residue sits in the top byte of hist_r, older ones shift toward byte 0.
  logic [kmwm_pkg::WIN_W-1:0]  hist_r;
  logic [kmwm_pkg::WIN_W-1:0]  hist_nxt;
  logic [kmwm_pkg::POS_W-1:0]  count_r;
  logic [kmwm_pkg::POS_W-1:0]  count_nxt;
  logic                        s1_valid_r;
  logic                        s1_valid_nxt;

  // Stage two: result register.
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic [kmwm_pkg::POS_W-1:0]  start_pos_r;
  logic [kmwm_pkg::CNT_W-1:0]  miss_cnt_r;
  logic [kmwm_pkg::WIN_W-1:0]  win_r;

  logic                        in_fire;
  logic                        s2_load;

  logic [kmwm_pkg::CNT_W-1:0]       len;
  logic [kmwm_pkg::CNT_W-1:0]       shift_bytes;
  logic [kmwm_pkg::WIN_W-1:0]       window;
  logic [kmwm_pkg::WIN_W-1:0]       pattern;
  logic [kmwm_pkg::PATTERN_MAX-1:0] miss_vec;
  logic [kmwm_pkg::CNT_W-1:0]       miss_cnt;
  logic [kmwm_pkg::POS_W-1:0]       start_pos;
  logic                             full;
  logic                             hit;

  // ---------------------------------------------------------------------------
  // Configuration writes. The user must write them only while the block is idle; it does not enforce this.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
      pat_len_r <= kmwm_pkg::CNT_W'(1);
      tol_r     <= kmwm_pkg::TOL;
    end else if (cfg_we) begin
      case (kmwm_pkg::cfg_index_t'(cfg_index))
        kmwm_pkg::CFG_PATTERN_LOW:    pat_lo_r  <= cfg_data;
        kmwm_pkg::CFG_PATTERN_HIGH:   pat_hi_r  <= cfg_data;
        kmwm_pkg::CFG_PATTERN_LENGTH: pat_len_r <= cfg_data[kmwm_pkg::CNT_W-1:0];
        kmwm_pkg::CFG_TOLERANCE:      tol_r     <= cfg_data[kmwm_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake. The result register frees up when it is empty or being taken,
  // and stage one may then hand its item over and take a new one in the same cycle.
  // ---------------------------------------------------------------------------
  assign s2_load  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_load;
  assign in_fire  = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Stage one next state. A line start restarts the count. The history itself is
  // not cleared: a window is only examined once the count covers its whole length,
  // so every byte that is read was written on the current line.
  // ---------------------------------------------------------------------------
  always_comb begin
    hist_nxt     = hist_r;
    count_nxt    = count_r;
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      hist_nxt     = {in_residue, hist_r[kmwm_pkg::WIN_W-1:kmwm_pkg::RES_W]};
      s1_valid_nxt = 1'b1;
      if (in_line_start) begin
        count_nxt = kmwm_pkg::POS_W'(1);
      end else if (count_r != kmwm_pkg::LINE_MAX) begin
        count_nxt = count_r + kmwm_pkg::POS_W'(1);
      end
    end else if (s2_load) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hist_r <= hist_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stage two: compare the newest len residues with the pattern.
  // Shifting the history right by (16 - len) bytes puts the oldest residue of the
  // window in byte 0 and fills bytes at and above len with zeros, which is exactly
  // the packing of the window fields.
  // ---------------------------------------------------------------------------
  assign len         = kmwm_pkg::active_len(pat_len_r);
  assign shift_bytes = kmwm_pkg::CNT_W'(kmwm_pkg::PATTERN_MAX) - len;
  assign window      = hist_r >> {shift_bytes, 3'b000};
  assign pattern     = {pat_hi_r, pat_lo_r};

  always_comb begin
    for (int i = 0; i < kmwm_pkg::PATTERN_MAX; i++) begin
      miss_vec[i] = (kmwm_pkg::CNT_W'(i) < len) &&
                    (window[i*kmwm_pkg::RES_W +: kmwm_pkg::RES_W] !=
                     pattern[i*kmwm_pkg::RES_W +: kmwm_pkg::RES_W]);
    end
  end

  assign miss_cnt  = kmwm_pkg::CNT_W'($countones(miss_vec));
  assign full      = count_r >= {{(kmwm_pkg::POS_W-kmwm_pkg::CNT_W){1'b0}}, len};
  // count_r >= len here, so the subtraction never wraps.
  assign start_pos = count_r - {{(kmwm_pkg::POS_W-kmwm_pkg::CNT_W){1'b0}}, len}
                     + kmwm_pkg::POS_W'(1);
  assign hit       = s1_valid_r && full && (miss_cnt <= tol_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s2_load) begin
      out_valid_nxt = hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && hit) begin
      start_pos_r <= start_pos;
      miss_cnt_r  <= miss_cnt;
      win_r       <= window;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_start_position = start_pos_r;
  assign out_mismatch_count = miss_cnt_r;
  assign out_window_low     = win_r[kmwm_pkg::HALF_W-1:0];
  assign out_window_high    = win_r[kmwm_pkg::WIN_W-1:kmwm_pkg::HALF_W];

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  `KMWM_ASSERT_IMP(a_stall_blocks_input, s1_valid_r && out_valid_r && !out_ready, !in_ready)
  `KMWM_ASSERT_IMP(a_result_within_tol, out_valid_r, miss_cnt_r <= tol_r)
  `KMWM_ASSERT_IMP(a_start_nonzero, out_valid_r, start_pos_r != '0)
  `KMWM_ASSERT_NXT(a_line_restart, in_fire && in_line_start, count_r == kmwm_pkg::POS_W'(1))
  `KMWM_ASSERT_NXT(a_count_steps, in_fire && !in_line_start && count_r != kmwm_pkg::LINE_MAX,
                   count_r == $past(count_r) + kmwm_pkg::POS_W'(1))

endmodule

// ===== test/testbench.sv =====
// Self-checking bench for the k-mismatch window matcher.
//
// A predictor inside this module keeps its own copy of the residue history,
// the line counter and the four pattern registers. Every residue item that the
// block accepts is run through it, and any match it finds is queued. A checker
// pops the oldest queued match for each result the block hands over and
// compares every field. The tests run one after another from a single initial
// block. They all share one task that offers an item, and one process that
// sets the receiver's idle pattern.
module testbench;
  import kmwm_pkg::*;

  // The longest back-pressure stretch, in cycles, that the receiver holds.
  localparam int HOLD_CYCLES   = 300;
  // The watchdog gives up after this many cycles in which no item moves.
  localparam int STALL_LIMIT   = 3000;
  // The block has two register stages, so this short drain covers anything in flight.
  localparam int DRAIN_CYCLES  = 4;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 90;
  localparam int REPORT_LIMIT  = 10;

  typedef struct {
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  miss;
    logic [HALF_W-1:0] win_lo;
    logic [HALF_W-1:0] win_hi;
  } match_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [RES_W-1:0]  in_residue;
  logic              in_line_start;
  logic              out_valid;
  logic              out_ready;
  logic [POS_W-1:0]  out_start_position;
  logic [CNT_W-1:0]  out_mismatch_count;
  logic [HALF_W-1:0] out_window_low;
  logic [HALF_W-1:0] out_window_high;

  k_mismatch_window_matcher uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_residue         (in_residue),
    .in_line_start      (in_line_start),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_start_position (out_start_position),
    .out_mismatch_count (out_mismatch_count),
    .out_window_low     (out_window_low),
    .out_window_high    (out_window_high)
  );

  // These are the predictor's own copies of the pattern registers and the line state.
  logic [HALF_W-1:0] pat_lo;
  logic [HALF_W-1:0] pat_hi;
  logic [CNT_W-1:0]  pat_len_reg;
  logic [CNT_W-1:0]  tol_reg;
  logic [RES_W-1:0]  history [PATTERN_MAX];
  int unsigned       line_count;
  match_t            pending_matches[$];

  // These are the idle percentages for each side, and the request for a long hold on the output.
  int in_idle_pct;
  int out_idle_pct;
  bit hold_req;

  int    items_sent;
  int    matches_checked;
  int    bad_results;
  int    settings_used;
  int    idle_cycles;
  string amino = "ACDEFGHIKLMNPQRSTVWY";

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // This returns a random gap length. Most gaps are zero or short, and a few are long.
  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  // This returns a random residue. It is mostly a real amino-acid letter, and
  // sometimes any byte at all, so that every bit of the field is exercised.
  function automatic logic [RES_W-1:0] random_residue();
    if ($urandom_range(4) == 0) return RES_W'($urandom_range(255));
    return amino[$urandom_range(19)];
  endfunction

  // This packs a string into pattern layout, with character 0 in the low byte.
  function automatic logic [2*HALF_W-1:0] pack_text(input string s);
    logic [2*HALF_W-1:0] packed_bytes;
    packed_bytes = '0;
    for (int i = 0; i < s.len() && i < PATTERN_MAX; i++) packed_bytes[8*i +: 8] = s[i];
    return packed_bytes;
  endfunction

  // This is the predictor. It shifts the residue into the history, clearing the
  // history first when a new line begins. Once the window is full it counts the
  // mismatches against the pattern. When that count is within the tolerance, the
  // function queues the match it expects the block to report.
  function automatic void predict_match(input logic [RES_W-1:0] r, input logic first);
    int unsigned n;
    int unsigned miss;
    int unsigned start;
    int unsigned i;
    logic [RES_W-1:0] w;
    logic [RES_W-1:0] p;
    match_t m;
    // A length of zero counts as one, and anything above the maximum is clipped.
    n = pat_len_reg;
    if (n == 0) n = 1;
    if (n > PATTERN_MAX) n = PATTERN_MAX;
    if (first) begin
      foreach (history[k]) history[k] = '0;
      line_count = 0;
    end
    for (i = PATTERN_MAX - 1; i > 0; i--) history[i] = history[i-1];
    history[0] = r;
    if (line_count < LINE_MAX) line_count++;
    if (line_count < n) return;
    miss     = 0;
    m.win_lo = '0;
    m.win_hi = '0;
    // Window position i holds the i-th oldest residue. Bytes beyond the length stay zero.
    for (i = 0; i < n; i++) begin
      w = history[n-1-i];
      p = (i < 8) ? pat_lo[8*i +: 8] : pat_hi[8*(i-8) +: 8];
      if (w != p) miss++;
      if (i < 8) m.win_lo[8*i +: 8] = w;
      else m.win_hi[8*(i-8) +: 8] = w;
    end
    if (miss > tol_reg) return;
    // After the counter saturates, the start position stops moving.
    start = line_count - n + 1;
    if (start > 16'hFFFF) start = 16'hFFFF;
    m.pos  = POS_W'(start);
    m.miss = CNT_W'(miss);
    pending_matches.push_back(m);
  endfunction

  // This offers one residue item. If valid was left high by the last item and
  // no gap is drawn, it stays high, so the next item follows back to back.
  task automatic send_residue(input logic [RES_W-1:0] r, input logic first);
    int gap;
    gap = pick_gap(in_idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_residue    <= r;
    in_line_start <= first;
    do @(posedge clk); while (!in_ready);
    predict_match(r, first);
    items_sent++;
  endtask

  // This drops valid and waits until every expected match has arrived. It then
  // waits out the drain time, so that items with no result leave the pipeline too.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // This writes all four registers on consecutive cycles, keeping the write enable
  // high throughout. Only the low five bits of the length and the tolerance count.
  task automatic load_config(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                             input logic [CFG_W-1:0] len_word,
                             input logic [CFG_W-1:0] tol_word);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PATTERN_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= CFG_PATTERN_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_index <= CFG_PATTERN_LENGTH;
    cfg_data  <= len_word;
    @(posedge clk);
    cfg_index <= CFG_TOLERANCE;
    cfg_data  <= tol_word;
    @(posedge clk);
    cfg_we      <= 1'b0;
    pat_lo      = lo;
    pat_hi      = hi;
    pat_len_reg = len_word[CNT_W-1:0];
    tol_reg     = tol_word[CNT_W-1:0];
    settings_used++;
  endtask

  // This sends one line built mostly from copies of the pattern, each with a few
  // mutations, with random filler in between. Now and then the line start flag
  // is left off, so that the line runs on into the one before it.
  task automatic send_random_line();
    logic [RES_W-1:0] line_bytes[$];
    int unsigned n;
    int unsigned target;
    int unsigned base;
    int unsigned i;
    logic [2*HALF_W-1:0] pat;
    bit fresh;
    n = pat_len_reg;
    if (n == 0) n = 1;
    if (n > PATTERN_MAX) n = PATTERN_MAX;
    pat    = {pat_hi, pat_lo};
    target = $urandom_range(40, 1);
    while (line_bytes.size() < target) begin
      if ($urandom_range(2) != 0) begin
        base = line_bytes.size();
        for (i = 0; i < n; i++) line_bytes.push_back(pat[8*i +: 8]);
        repeat ($urandom_range(3)) line_bytes[base + $urandom_range(n - 1)] = random_residue();
      end else begin
        repeat ($urandom_range(5)) line_bytes.push_back(random_residue());
      end
    end
    fresh = ($urandom_range(19) != 0);
    foreach (line_bytes[k]) send_residue(line_bytes[k], fresh && (k == 0));
  endtask

  // Reset leaves length 1, tolerance 2 and a zero pattern. Every residue is then a
  // match. Residues sent before any line start count as a line that began at reset.
  task automatic test_reset_defaults();
    in_idle_pct  = 30;
    out_idle_pct = 30;
    send_residue(8'h00, 1'b0);
    send_residue(8'hFF, 1'b0);
    send_residue(8'h55, 1'b0);
    send_residue(8'hAA, 1'b1);
    send_residue(8'h41, 1'b0);
  endtask

  // These are directed register settings: a length above the maximum with a tolerance
  // of 31, a zero length, and a short pattern with junk in its unused bytes.
  task automatic test_directed_cases();
    logic [2*HALF_W-1:0] pat;
    string full;
    full = "ACDEFGHIKLMNPQRS";
    pat  = pack_text(full);
    // With the length clipped to 16 and the tolerance above it, every full window
    // is reported, even one in which all sixteen positions differ.
    settle();
    load_config(pat[63:0], pat[127:64], 64'd31, 64'd31);
    for (int i = 0; i < PATTERN_MAX; i++) send_residue(full[i], i == 0);
    send_residue("T", 1'b0);
    // A zero length acts as one. Only byte 0 of the pattern counts, and the
    // unused window bytes come back as zero.
    settle();
    load_config({HALF_W{1'b1}}, {HALF_W{1'b1}}, 64'd0, 64'd0);
    send_residue(8'hFF, 1'b1);
    send_residue(8'h00, 1'b0);
    send_residue(8'hFF, 1'b0);
    send_residue(8'h7F, 1'b0);
    // A length of 2 with a tolerance of 1. The pattern bytes beyond the length are junk.
    settle();
    pat = pack_text("AC");
    load_config({48'hDEAD_BEEF_F00D, pat[15:0]}, 64'hA5A5_5A5A_0F0F_F0F0, 64'd2, 64'd1);
    send_residue("A", 1'b1);
    send_residue("C", 1'b0);
    send_residue("X", 1'b0);
    send_residue("C", 1'b0);
  endtask

  // Each random phase draws a new pattern, length and tolerance, and sets how
  // often each side idles. Two of the phases run with no idling at all.
  task automatic test_random_lines();
    logic [2*HALF_W-1:0] pat;
    logic [CFG_W-1:0] len_word;
    logic [CFG_W-1:0] tol_word;
    int phase_start;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      for (int i = 0; i < PATTERN_MAX; i++) begin
        pat[8*i +: 8] = phase[0] ? RES_W'($urandom_range(255)) : amino[$urandom_range(19)];
      end
      case ($urandom_range(9))
        0:       len_word = 64'd0;
        1:       len_word = CFG_W'($urandom_range(31, 17));
        default: len_word = CFG_W'($urandom_range(16, 1));
      endcase
      tol_word = ($urandom_range(3) == 0) ? CFG_W'($urandom_range(31)) : CFG_W'($urandom_range(3));
      // In one phase the unused upper bits of the write data are randomized, and the block must ignore them.
      if (phase == 3) begin
        len_word = ({$urandom, $urandom} & ~64'h1F) | len_word;
        tol_word = ({$urandom, $urandom} & ~64'h1F) | tol_word;
      end
      load_config(pat[63:0], pat[127:64], len_word, tol_word);
      in_idle_pct  = (phase % 5 == 0) ? 0 : $urandom_range(60, 10);
      out_idle_pct = (phase % 5 == 0) ? 0 : $urandom_range(60, 10);
      phase_start  = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) send_random_line();
    end
  endtask

  // The receiver holds off for a long stretch while every window matches, so the
  // block fills up and has to stall its input.
  task automatic test_backpressure();
    logic [2*HALF_W-1:0] pat;
    settle();
    pat = pack_text("MKLV");
    load_config(pat[63:0], pat[127:64], 64'd4, 64'd16);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_req     = 1'b1;
    for (int i = 0; i < 60; i++) send_residue(random_residue(), i == 0);
    out_idle_pct = 20;
  endtask

  // This process idles the receiver at random, and holds it off for one long
  // stretch when a test asks for it.
  initial begin : receiver
    int stall;
    out_ready <= 1'b0;
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stall = pick_gap(out_idle_pct);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end else begin
          out_ready <= 1'b1;
          @(posedge clk);
        end
      end
    end
  end

  task automatic report_error(input string msg);
    bad_results++;
    if (bad_results <= REPORT_LIMIT) $display("%s", msg);
  endtask

  // Each result the block hands over must match the oldest queued prediction in every field.
  always @(posedge clk) begin : result_check
    match_t want;
    if (rst_n && out_valid && out_ready) begin
      matches_checked++;
      if (pending_matches.size() == 0) begin
        report_error($sformatf("unexpected match: pos %0d miss %0d window %h_%h",
                               out_start_position, out_mismatch_count,
                               out_window_high, out_window_low));
      end else begin
        want = pending_matches.pop_front();
        if (out_start_position !== want.pos || out_mismatch_count !== want.miss ||
            out_window_low !== want.win_lo || out_window_high !== want.win_hi) begin
          report_error($sformatf(
            "match differs: want pos %0d miss %0d window %h_%h, got pos %0d miss %0d window %h_%h",
            want.pos, want.miss, want.win_hi, want.win_lo, out_start_position,
            out_mismatch_count, out_window_high, out_window_low));
        end
      end
    end
  end

  // The run is stuck if no item moves on either side for too long.
  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_PATTERN_LOW;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    in_residue    <= '0;
    in_line_start <= 1'b0;
    // The predictor starts in the block's reset state.
    pat_lo          = '0;
    pat_hi          = '0;
    pat_len_reg     = CNT_W'(1);
    tol_reg         = TOL;
    foreach (history[k]) history[k] = '0;
    line_count      = 0;
    hold_req        = 1'b0;
    in_idle_pct     = 0;
    out_idle_pct    = 0;
    items_sent      = 0;
    matches_checked = 0;
    bad_results     = 0;
    settings_used   = 0;
    idle_cycles     = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_directed_cases();
    test_random_lines();
    test_backpressure();
    settle();

    $display("Scanned %0d residues under %0d register settings and checked %0d matches,",
             items_sent, settings_used, matches_checked);
    $display("including clipped lengths, wide tolerances, line restarts and a long output hold.");
    if (bad_results == 0 && pending_matches.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d bad results, %0d matches never seen", bad_results, pending_matches.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
